// File: src/dsgfc_pkg.sv
package dsgfc_pkg;

    localparam int PHASE_W   = 32;
    localparam int GATE_W    = 16;
    localparam int WRAP_W    = 8;
    localparam int CVAL_W    = 16;
    localparam int DUTY_W    = 8;
    localparam int TOTAL_W   = 24;
    localparam int LUT_IDX_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_TICKS = 2'd1;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'h0400_0000;
    localparam logic [GATE_W-1:0]  GATE_TICKS_RST = 16'd1569;

    typedef struct packed {
        logic              start_request;
        logic              counter_wrapped;
        logic [CVAL_W-1:0] counter_value;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic               counter_enable;
        logic               result_valid;
        logic [TOTAL_W-1:0] edge_total;
    } t_out_item;

    // Measurement outcome handed from the gate counter to the top level
    typedef struct packed {
        logic               counter_enable;
        logic               result_valid;
        logic [TOTAL_W-1:0] edge_total;
    } t_gate_res;

    localparam logic [DUTY_W-1:0] SINE_LUT [2**LUT_IDX_W] = '{
        8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd178, 8'd181, 8'd184, 8'd187, 8'd190, 8'd192, 8'd195,
        8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd212, 8'd215,
        8'd217, 8'd219, 8'd221, 8'd223, 8'd225, 8'd227, 8'd229, 8'd231,
        8'd233, 8'd234, 8'd236, 8'd238, 8'd239, 8'd240, 8'd242, 8'd243,
        8'd244, 8'd245, 8'd247, 8'd248, 8'd249, 8'd249, 8'd250, 8'd251,
        8'd252, 8'd252, 8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254,
        8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253, 8'd253, 8'd252,
        8'd252, 8'd251, 8'd250, 8'd249, 8'd249, 8'd248, 8'd247, 8'd245,
        8'd244, 8'd243, 8'd242, 8'd240, 8'd239, 8'd238, 8'd236, 8'd234,
        8'd233, 8'd231, 8'd229, 8'd227, 8'd225, 8'd223, 8'd221, 8'd219,
        8'd217, 8'd215, 8'd212, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
        8'd198, 8'd195, 8'd192, 8'd190, 8'd187, 8'd184, 8'd181, 8'd178,
        8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
        8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130,
        8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd111, 8'd108, 8'd105,
        8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
        8'd78,  8'd76,  8'd73,  8'd70,  8'd67,  8'd64,  8'd62,  8'd59,
        8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd42,  8'd39,
        8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
        8'd21,  8'd20,  8'd18,  8'd16,  8'd15,  8'd14,  8'd12,  8'd11,
        8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
        8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
        8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
        8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd16,  8'd18,  8'd20,
        8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
        8'd37,  8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
        8'd56,  8'd59,  8'd62,  8'd64,  8'd67,  8'd70,  8'd73,  8'd76,
        8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
        8'd102, 8'd105, 8'd108, 8'd111, 8'd115, 8'd118, 8'd121, 8'd124
    };

endpackage

// File: src/dsgfc_dds.sv
module dsgfc_dds
    import dsgfc_pkg::*;
#(
    parameter int TABLE_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [PHASE_W-1:0] i_phase_step,
    output logic [DUTY_W-1:0]  o_duty
);

    // Phase bits that survive the table resolution, capped at the table index width
    localparam int KEEP_BITS = (TABLE_BITS < LUT_IDX_W) ? TABLE_BITS : LUT_IDX_W;
    localparam logic [LUT_IDX_W-1:0] IDX_MASK = ~({LUT_IDX_W{1'b1}} >> KEEP_BITS);

    logic [PHASE_W-1:0]   r_phase;
    logic [PHASE_W-1:0]   n_phase;
    logic [LUT_IDX_W-1:0] lut_idx;

    assign n_phase = r_phase + i_phase_step;
    assign lut_idx = n_phase[PHASE_W-1 -: LUT_IDX_W] & IDX_MASK;
    assign o_duty  = SINE_LUT[lut_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
        end
    end

endmodule

// File: src/dsgfc_gate.sv
module dsgfc_gate
    import dsgfc_pkg::*;
#(
    parameter int COUNTER_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  t_in_item          i_item,
    input  logic [GATE_W-1:0] i_gate_ticks,
    output t_gate_res         o_res
);

    localparam int SUM_W = (COUNTER_BITS + WRAP_W > TOTAL_W) ?
                           (COUNTER_BITS + WRAP_W) : TOTAL_W;
    localparam logic [SUM_W-1:0] CVAL_MASK = (SUM_W'(1) << COUNTER_BITS) - SUM_W'(1);

    logic              r_start_pending;
    logic              r_measuring;
    logic [GATE_W-1:0] r_gate_count;
    logic [WRAP_W-1:0] r_wrap_count;

    logic              n_start_pending;
    logic              n_measuring;
    logic [GATE_W-1:0] n_gate_count;
    logic [WRAP_W-1:0] n_wrap_count;

    logic [GATE_W-1:0] gate_base;
    logic [WRAP_W-1:0] wrap_base;
    logic              pend_base;
    logic              done;
    logic [SUM_W-1:0]  sum;

    // A start request clears the counts before this tick's gate step
    assign gate_base = i_item.start_request ? '0 : r_gate_count;
    assign wrap_base = i_item.start_request ? '0 : r_wrap_count;
    assign pend_base = i_item.start_request | r_start_pending;
    assign done      = r_measuring && (gate_base >= i_gate_ticks);

    assign sum = (SUM_W'(wrap_base) << COUNTER_BITS)
               + (SUM_W'(i_item.counter_value) & CVAL_MASK);

    always_comb begin
        n_start_pending = pend_base;
        n_measuring     = r_measuring;
        n_gate_count    = gate_base;
        n_wrap_count    = wrap_base;
        if (r_measuring) begin
            if (done) begin
                n_measuring = 1'b0;
            end else begin
                n_gate_count = gate_base + GATE_W'(1);
                if (i_item.counter_wrapped) begin
                    n_wrap_count = wrap_base + WRAP_W'(1);
                end
            end
        end else if (pend_base) begin
            n_start_pending = 1'b0;
            n_measuring     = 1'b1;
        end
    end

    assign o_res.counter_enable = n_measuring;
    assign o_res.result_valid   = done;
    assign o_res.edge_total     = done ? sum[TOTAL_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pending <= 1'b0;
            r_measuring     <= 1'b0;
            r_gate_count    <= '0;
            r_wrap_count    <= '0;
        end else if (i_advance) begin
            r_start_pending <= n_start_pending;
            r_measuring     <= n_measuring;
            r_gate_count    <= n_gate_count;
            r_wrap_count    <= n_wrap_count;
        end
    end

endmodule

// File: src/dds_sine_with_gated_freq_counter_unit.sv
// DDS sine generator with a gated frequency counter.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one transfer per reference
// tick, carrying the start request and the external edge counter's wrap flag and
// value. Every tick yields exactly one result on the output channel
// (o_out_valid / i_out_ready / o_out_data): the PWM duty from the sine table, the
// counter enable, and on the tick a gate closes, result_valid with edge_total.
//
// A transferred tick is registered in the output register, or the skid register if
// that is held. Throughput is one tick per clock while o_in_ready is high; the
// phase adder, gate compare and table read feed the output stage combinationally.
// A two-entry output stage (output register plus skid register) keeps o_in_ready
// high while one result waits; o_in_ready only drops once both entries are full,
// so a stalled receiver backs up the input after two ticks.
//
// Configuration (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is always
// ready; index 0 is the phase step, 1 the gate length, others are ignored.
// Write it only while no tick is in flight.
// Synchronous reset clears phase, measurement state and both output entries and
// restores the default phase step and gate length. No clearing pass is needed.
module dds_sine_with_gated_freq_counter_unit
    import dsgfc_pkg::*;
#(
    parameter int TABLE_BITS   = 8,
    parameter int COUNTER_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [PHASE_W-1:0] r_phase_step;
    logic [GATE_W-1:0]  r_gate_ticks;

    // Output stage: main register and skid entry
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      r_skid_valid;
    t_out_item r_skid_data;

    logic      in_xfer;
    logic      out_xfer;
    logic      cfg_xfer;
    logic      load_main;

    logic [DUTY_W-1:0] duty;
    t_gate_res         gate_res;
    t_out_item         new_item;

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid & o_cfg_ready;

    // Ready depends only on the skid entry, never on i_out_ready
    assign o_in_ready = ~r_skid_valid;
    assign in_xfer    = i_in_valid & o_in_ready;
    assign out_xfer   = r_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= PHASE_STEP_RST;
            r_gate_ticks <= GATE_TICKS_RST;
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data[PHASE_W-1:0];
                CFG_GATE_TICKS: r_gate_ticks <= i_cfg_data[GATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dsgfc_dds #(
        .TABLE_BITS (TABLE_BITS)
    ) u_dds (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (in_xfer),
        .i_phase_step (r_phase_step),
        .o_duty       (duty)
    );

    dsgfc_gate #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_gate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (in_xfer),
        .i_item       (i_in_data),
        .i_gate_ticks (r_gate_ticks),
        .o_res        (gate_res)
    );

    assign new_item.duty           = duty;
    assign new_item.counter_enable = gate_res.counter_enable;
    assign new_item.result_valid   = gate_res.result_valid;
    assign new_item.edge_total     = gate_res.edge_total;

    // New result goes straight to the main register when it is free or draining
    assign load_main = ~r_out_valid | out_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                if (load_main) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_xfer) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            if (load_main) begin
                r_out_data <= new_item;
            end else begin
                r_skid_data <= new_item;
            end
        end else if (out_xfer && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // Skid entry is only ever filled behind a held main entry
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // A tick taken while the output is empty shows up on the next cycle
    a_one_cycle_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !r_out_valid) |=> r_out_valid)
        else $error("accepted tick did not reach the output register");

    // Closing a gate ends the measurement in the same result
    a_done_disables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.result_valid) |-> !r_out_data.counter_enable)
        else $error("counter still enabled on a completed measurement");

    // Total is zero whenever no measurement completes
    a_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.result_valid) |-> (r_out_data.edge_total == '0))
        else $error("edge total nonzero without a completed measurement");
`endif

endmodule
